// ===== design/plf_pkg.sv =====
// Package for the PCM little-endian to float32 unpacker.
// Types, constants and the bytes-per-sample function; no dependencies.
package plf_pkg;

    typedef enum logic [1:0] {
        MODE_16 = 2'd0,
        MODE_24 = 2'd1,
        MODE_32 = 2'd2,
        MODE_64 = 2'd3
    } width_mode_t;

    localparam int ACC_W = 56;

    // Number of bytes in one sample for a width mode.
    function automatic logic [3:0] bytes_per_sample(input width_mode_t mode);
        logic [3:0] n;
        begin
            unique case (mode)
                MODE_16: n = 4'd2;
                MODE_24: n = 4'd3;
                MODE_32: n = 4'd4;
                default: n = 4'd8;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== design/plf_convert.sv =====
// Float32 conversion of a left-justified signed 64-bit sample (scaled 2^-63).
// Combinational conversion into a registered result; no package dependency.
module plf_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_error,
    input  logic [63:0] in_raw,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [32:0] out_data,   // [31:0] sample_bits, [32] error
    output logic        in_ready
);
    logic        sign;
    logic [63:0] mag;
    logic [5:0]  lead;
    logic [63:0] norm;
    logic [23:0] mant;
    logic        round_up;
    logic [24:0] mant_r;
    logic [7:0]  expo;
    logic [31:0] bits;
    logic        valid_reg;
    logic [32:0] data_reg;

    always_comb begin
        sign = in_raw[63];
        mag  = sign ? (~in_raw + 64'd1) : in_raw;
        lead = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) lead = 6'(i);
        end
        norm = mag << (6'd63 - lead);
        mant = norm[63:40];
        // round to nearest even on the bits below the kept 24
        round_up = norm[39] && ((|norm[38:0]) || norm[40]);
        mant_r = {1'b0, mant} + {24'd0, round_up};
        expo = 8'(lead) + 8'd64 + {7'd0, mant_r[24]};
        if (mag == 64'd0) begin
            bits = 32'd0;
        end else begin
            bits = {sign, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_error ? {1'b1, 32'd0} : {1'b0, bits};
        end
    end
endmodule

// ===== design/pcm_le_to_float_unpacker.sv =====
// Top level of the PCM little-endian to float32 unpacker.
// Depends on plf_pkg and plf_convert.
//
// Usage: bytes enter on the s_axis channel, one per beat, tdata = data_byte,
// tlast marks the final byte of a buffer. Results leave on m_axis with
// tdata = sample_bits and tuser = error. The sample width mode is written on
// the cfg channel (cfg_valid/cfg_ready/cfg_data), only while idle; a write
// drops any partial sample.
// Throughput: one byte per cycle while the receiver does not stall. Bytes are
// gathered in an accumulator; the beat that completes a sample (or ends a ragged
// buffer) is captured in an input register, converted by the leading-one search,
// shift and rounding between that register and the result register, which drives
// m_axis_tvalid.
// Reset clears the mode to 16 bits, the accumulator, count and all valids.
// When the receiver stalls, the result and input registers fill and
// s_axis_tready drops until m_axis_tready returns; no beat is lost.
module pcm_le_to_float_unpacker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,          // sample_width_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // [7:0] data_byte
    input  logic        s_axis_tlast,      // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,      // [31:0] sample_bits
    output logic [0:0]  m_axis_tuser       // [0] error
);
    plf_pkg::width_mode_t mode_reg;
    logic [plf_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]  count_reg, count_next;
    logic        seen_reg, seen_next;
    logic        stage_valid_reg;
    logic        stage_error_reg;
    logic [63:0] stage_raw_reg;
    logic        stage_ready;
    logic        take;
    logic        complete;
    logic        emit;
    logic        emit_error;
    logic [3:0]  size;
    logic [63:0] full;
    logic [63:0] raw;
    logic [32:0] conv_data;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !stage_valid_reg || stage_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign size          = plf_pkg::bytes_per_sample(mode_reg);

    always_comb begin
        complete   = ({1'b0, count_reg} + 4'd1) >= size;
        full       = {8'd0, acc_reg} | ({56'd0, s_axis_tdata} << {count_reg, 3'b000});
        raw        = full << (7'd64 - {size, 3'b000});
        acc_next   = acc_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        emit_error = 1'b0;
        if (complete) begin
            acc_next   = '0;
            count_next = 3'd0;
            seen_next  = 1'b1;
        end else begin
            acc_next   = full[plf_pkg::ACC_W-1:0];
            count_next = count_reg + 3'd1;
        end
        if (s_axis_tlast) begin
            emit_error = (count_next != 3'd0) && seen_next;
            acc_next   = '0;
            count_next = 3'd0;
            seen_next  = 1'b0;
        end
        emit = complete || emit_error;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= plf_pkg::MODE_16;
            acc_reg   <= '0;
            count_reg <= 3'd0;
            seen_reg  <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg  <= plf_pkg::width_mode_t'(cfg_data);
            acc_reg   <= '0;
            count_reg <= 3'd0;
        end else if (take) begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            stage_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            stage_error_reg <= emit_error;
            stage_raw_reg   <= raw;
        end
    end

    plf_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid_reg),
        .in_error  (stage_error_reg),
        .in_raw    (stage_raw_reg),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (conv_data),
        .in_ready  (stage_ready)
    );

    assign m_axis_tdata = conv_data[31:0];
    assign m_axis_tuser = conv_data[32:32];

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} < size) || $past(cfg_valid))
        else $error("byte count reached sample size");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_axis_tlast && !cfg_valid |=> count_reg == 3'd0 && !seen_reg)
        else $error("buffer end did not clear state");
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("error result carries data");
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> count_reg == 3'd0)
        else $error("mode write kept partial sample");
endmodule

// ===== test/tb_top.sv =====
// Testbench for pcm_le_to_float_unpacker: random byte buffers in all width modes,
// results checked against an in-bench float32 conversion. Depends on plf_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        logic [31:0] bits;
        logic        err;
    } float_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    pcm_le_to_float_unpacker u_dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    plf_pkg::width_mode_t mdl_mode = plf_pkg::MODE_16;
    logic [63:0] mdl_acc = '0;
    int          mdl_cnt = 0;
    bit          mdl_seen = 0;

    byte_beat_t  pending_bytes[$];
    float_res_t  expected_floats[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_sender = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          stall_mode = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] float_of(logic [63:0] raw);
        logic        sgn;
        logic [63:0] mag, rem, half, mant;
        int          p, sh;
        sgn = raw[63];
        mag = sgn ? -raw : raw;
        if (mag == 0) return 32'h0;
        p = 63;
        while (!mag[p]) p--;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
                mant >>= 1;
                p++;
            end
        end
        return {sgn, 8'(p + 64), mant[22:0]};
    endfunction

    function automatic void predict(byte_beat_t bb);
        int         nbytes;
        logic [63:0] smp;
        nbytes = int'(plf_pkg::bytes_per_sample(mdl_mode));
        if (mdl_cnt + 1 >= nbytes) begin
            smp = mdl_acc | (64'(bb.data_byte) << (8 * mdl_cnt));
            smp <<= 64 - 8 * nbytes;
            expected_floats.push_back('{float_of(smp), 1'b0});
            mdl_acc = '0;
            mdl_cnt = 0;
            mdl_seen = 1;
        end else begin
            mdl_acc |= 64'(bb.data_byte) << (8 * mdl_cnt);
            mdl_cnt++;
        end
        if (bb.last) begin
            if (mdl_cnt != 0 && mdl_seen) expected_floats.push_back('{32'h0, 1'b1});
            mdl_acc = '0;
            mdl_cnt = 0;
            mdl_seen = 0;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) predict('{s_axis_tdata, s_axis_tlast});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid && s_axis_tready) gap_left = gap_len();
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0 && !hold_sender) begin
                    s_axis_tvalid <= 1'b1;
                    {s_axis_tdata, s_axis_tlast} <= pending_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        float_res_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_floats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result bits=%h err=%b", m_axis_tdata,
                                 m_axis_tuser);
                end else begin
                    want = expected_floats.pop_front();
                    if (want.bits !== m_axis_tdata || want.err !== m_axis_tuser[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp bits=%h err=%b, got bits=%h err=%b",
                                     want.bits, want.err, m_axis_tdata, m_axis_tuser);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (stall_mode) stall_left = gap_len();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("[pcm_le_to_float_unpacker] ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_floats.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(plf_pkg::width_mode_t m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mdl_mode = m;
        mdl_acc = '0;
        mdl_cnt = 0;
    endtask

    // one buffer: whole samples, then sometimes a ragged tail
    task automatic queue_buffer(int nbytes, int samples, int tail);
        int total;
        total = samples * nbytes + tail;
        if (total == 0) total = 1;
        for (int i = 0; i < total; i++)
            pending_bytes.push_back('{8'($urandom), i == total - 1});
    endtask

    initial begin
        plf_pkg::width_mode_t m;
        int          nb;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        stall_mode = 1;

        // directed: extremes in 16-bit mode, short and ragged buffers
        pending_bytes.push_back('{8'h00, 1'b0}); pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'hff, 1'b0}); pending_bytes.push_back('{8'h7f, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0}); pending_bytes.push_back('{8'h80, 1'b0});
        pending_bytes.push_back('{8'hff, 1'b0}); pending_bytes.push_back('{8'hff, 1'b0});
        pending_bytes.push_back('{8'h55, 1'b1});                      // ragged
        pending_bytes.push_back('{8'haa, 1'b1});                      // short
        drain();
        // 64-bit: rounding carry up to 1.0, and a value whose lowest kept bit is set
        write_mode(plf_pkg::MODE_64);
        for (int i = 0; i < 8; i++) pending_bytes.push_back('{i == 7 ? 8'h7f : 8'hff, 1'b0});
        for (int i = 0; i < 8; i++)
            pending_bytes.push_back('{i == 4 ? 8'h80 : (i == 7 ? 8'h40 : 8'h00), i == 7});
        // pause sender after the first sample until its result is out
        while (pending_bytes.size() > 8) @(posedge aclk);
        hold_sender = 1'b1;
        while (s_axis_tvalid || expected_floats.size() > 0) @(posedge aclk);
        hold_sender = 1'b0;
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            m = plf_pkg::width_mode_t'(ph < 4 ? ph : $urandom_range(0, 3));
            write_mode(m);
            nb = int'(plf_pkg::bytes_per_sample(m));
            stall_mode = (ph % 3 != 2);
            while (pending_bytes.size() < 55) begin
                if ($urandom_range(0, 9) == 0)
                    queue_buffer(nb, 0, $urandom_range(1, nb - 1));
                else
                    queue_buffer(nb, $urandom_range(1, 6),
                                 $urandom_range(0, 2) == 0 ? $urandom_range(1, nb - 1) : 0);
            end
        end
        drain();
        if (mismatches == 0)
            $display("[pcm_le_to_float_unpacker] OK");
        else
            $display("[pcm_le_to_float_unpacker] ERROR");
        $finish;
    end
endmodule
